// ===== design/spli_pkg.sv =====
// ----------------------------------------------------------------------------
// spli_pkg
// Types and constants of the sample player with linear interpolation.
// ----------------------------------------------------------------------------
package spli_pkg;

  localparam int unsigned TABLE_DEPTH = 65536;
  localparam int unsigned ADDR_W      = 16;
  localparam int unsigned SAMPLE_W    = 16;
  localparam int unsigned FRAC_W      = 16;
  localparam int unsigned POS_W       = 32;
  localparam int unsigned LEN_W       = 17;
  localparam int unsigned SPAN_W      = LEN_W + FRAC_W;
  localparam int unsigned RATE_W      = 18;
  localparam int unsigned START_W     = 32;
  localparam int unsigned SPEED_W     = 24;
  localparam int unsigned PROD_W      = START_W + RATE_W;
  localparam int unsigned SUM_W       = POS_W + 2;
  localparam int unsigned CNT_W       = 6;
  localparam int unsigned CFG_W       = 18;
  localparam int unsigned IN_DATA_W   = 96;
  localparam int unsigned OUT_DATA_W  = 16;

  localparam logic [RATE_W-1:0] RATE_RESET = 18'd48000;
  localparam logic [LEN_W-1:0]  LEN_MAX    = 17'd65536;

  // register indexes
  localparam logic REG_TABLE_LENGTH = 1'b0;
  localparam logic REG_SAMPLE_RATE  = 1'b1;

  // item kinds
  localparam logic CMD_TICK  = 1'b0;
  localparam logic CMD_WRITE = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL,
    ST_MOD_RST,
    ST_MOD_POS,
    ST_READ0,
    ST_READ1,
    ST_IMUL,
    ST_MOD_SPD,
    ST_ADD,
    ST_WRAP,
    ST_DONE
  } state_e;

endpackage

// ===== design/sample_player_linear_interp_top.sv =====
// ----------------------------------------------------------------------------
// sample_player_linear_interp_top
// One-channel sample player with linear interpolation.
//
// Input items arrive on s_axis. tuser selects the kind: a write item stores
// one sample into the 64K-entry sample memory and gives no result; a tick
// item gives exactly one result on m_axis (interpolated sample in tdata,
// playing flag in tuser). Registers table_length and sample_rate are written
// on the cfg channel, which is always ready.
// A write item is stored as it is accepted. A tick with the position in range
// and the speed below the table span reads two samples and interpolates; the
// stale-position reduction, a speed of at least the span and a position reload
// each add a reduction. All reductions run one remainder bit per cycle on one
// shared compare-subtract unit, so one tick is at work at a time.
// The result sits in an output register; a stalled receiver holds the block
// before it finishes the next tick. Reset clears the position, the length and
// the output register and sets the sample rate to 48000; the sample memory
// holds whatever it held.
// ----------------------------------------------------------------------------
module sample_player_linear_interp_top (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // reload, gate, start[31:0], speed[23:0],
  // write_address[15:0], write_data[15:0], zero fill
  input  logic [spli_pkg::IN_DATA_W-1:0]    s_axis_tdata,
  // cmd
  input  logic                              s_axis_tuser,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // sample_out[15:0]
  output logic [spli_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
  // playing
  output logic                              m_axis_tuser,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic                              cfg_addr_i,
  input  logic [spli_pkg::CFG_W-1:0]        cfg_data_i
);
  import spli_pkg::*;

  state_e state_q, state_d;

  logic [LEN_W-1:0]    table_length_q;
  logic [RATE_W-1:0]   rate_q;
  logic [POS_W-1:0]    pos_q;
  logic [START_W-1:0]  start_q;
  logic [SPEED_W-1:0]  speed_q;
  logic                reset_trig_q;
  logic                playing_q;
  logic [PROD_W-1:0]   op_q;
  logic [POS_W-1:0]    rem_q;
  logic [CNT_W-1:0]    cnt_q;
  logic [SAMPLE_W-1:0] s0_q;
  logic [SAMPLE_W-1:0] rd_q;
  logic signed [2*SAMPLE_W+1:0] dprod_q;
  logic [SUM_W-1:0]    sum_q;
  logic [SAMPLE_W-1:0] res_q;
  logic                m_valid_q;
  logic [SAMPLE_W-1:0] m_data_q;
  logic                m_user_q;

  logic [SAMPLE_W-1:0] mem [TABLE_DEPTH];

  logic                in_acc, is_tick, is_write;
  logic [LEN_W-1:0]    len;
  logic [SPAN_W-1:0]   span;
  logic                in_reset, in_gate;
  logic [START_W-1:0]  in_start;
  logic [SPEED_W-1:0]  in_speed;
  logic [ADDR_W-1:0]   in_waddr;
  logic [SAMPLE_W-1:0] in_wdata;
  logic [SPAN_W-1:0]   step_t, step_sub;
  logic [POS_W-1:0]    rem_next;
  logic                step_last;
  logic [SPEED_W-1:0]  speed_mag;
  logic [ADDR_W-1:0]   idx0, idx1, rd_addr;
  logic [ADDR_W:0]     idx0_inc;
  logic [PROD_W-1:0]   prod;
  logic signed [SAMPLE_W:0] diff;
  logic [SUM_W-1:0]    sum_wrap;
  logic [SAMPLE_W:0]   interp;
  logic                out_free;

  assign in_reset = s_axis_tdata[0];
  assign in_gate  = s_axis_tdata[1];
  assign in_start = s_axis_tdata[33:2];
  assign in_speed = s_axis_tdata[57:34];
  assign in_waddr = s_axis_tdata[73:58];
  assign in_wdata = s_axis_tdata[89:74];

  assign in_acc   = s_axis_tvalid && s_axis_tready;
  assign is_tick  = in_acc && (s_axis_tuser == CMD_TICK);
  assign is_write = in_acc && (s_axis_tuser == CMD_WRITE);

  assign len  = (table_length_q > LEN_MAX) ? LEN_MAX : table_length_q;
  assign span = {len, {FRAC_W{1'b0}}};

  // shared remainder unit: one bit of the operand per cycle
  assign step_t    = {rem_q, op_q[PROD_W-1]};
  assign step_sub  = step_t - span;
  assign rem_next  = (step_t >= span) ? step_sub[POS_W-1:0] : step_t[POS_W-1:0];
  assign step_last = (cnt_q == CNT_W'(1));

  assign speed_mag = speed_q[SPEED_W-1] ? SPEED_W'(-speed_q) : speed_q;

  assign idx0     = pos_q[POS_W-1:FRAC_W];
  assign idx0_inc = {1'b0, idx0} + (ADDR_W+1)'(1);
  assign idx1     = (idx0_inc == len) ? '0 : idx0_inc[ADDR_W-1:0];
  assign rd_addr  = (state_q == ST_READ1) ? idx1 : idx0;

  assign prod = PROD_W'(start_q) * PROD_W'(rate_q);
  assign diff = $signed({rd_q[SAMPLE_W-1], rd_q}) - $signed({s0_q[SAMPLE_W-1], s0_q});
  assign interp = {s0_q[SAMPLE_W-1], s0_q} + dprod_q[2*SAMPLE_W:FRAC_W];

  assign sum_wrap = sum_q[SUM_W-1] ? sum_q + SUM_W'(span) :
                    (sum_q >= SUM_W'(span)) ? sum_q - SUM_W'(span) : sum_q;

  assign out_free = !m_valid_q || m_axis_tready;

  assign cfg_ready_o   = 1'b1;
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_user_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d       = state_q;
    s_axis_tready = 1'b0;
    case (state_q)
      ST_IDLE: begin
        s_axis_tready = 1'b1;
        if (is_tick) begin
          if (len == '0) begin
            state_d = ST_DONE;
          end else if (in_reset) begin
            state_d = ST_MUL;
          end else if (!in_gate) begin
            state_d = ST_DONE;
          end else if (POS_W'(pos_q) >= span) begin
            state_d = ST_MOD_POS;
          end else begin
            state_d = ST_READ0;
          end
        end
      end
      ST_MUL:     state_d = ST_MOD_RST;
      ST_MOD_RST: if (step_last) state_d = playing_q ? ST_READ0 : ST_DONE;
      ST_MOD_POS: if (step_last) state_d = ST_READ0;
      ST_READ0:   state_d = ST_READ1;
      ST_READ1:   state_d = ST_IMUL;
      ST_IMUL:    state_d = (SPAN_W'(speed_mag) < span) ? ST_ADD : ST_MOD_SPD;
      ST_MOD_SPD: if (step_last) state_d = ST_ADD;
      ST_ADD:     state_d = ST_WRAP;
      ST_WRAP:    state_d = ST_DONE;
      ST_DONE:    if (out_free) state_d = ST_IDLE;
      default:    state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      table_length_q <= '0;
      rate_q         <= RATE_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_addr_i)
        REG_TABLE_LENGTH: table_length_q <= cfg_data_i[LEN_W-1:0];
        REG_SAMPLE_RATE:  rate_q         <= cfg_data_i[RATE_W-1:0];
        default:          table_length_q <= table_length_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (is_write) begin
      mem[in_waddr] <= in_wdata;
    end
    rd_q <= mem[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
    end else if ((state_q == ST_MOD_RST || state_q == ST_MOD_POS) && step_last) begin
      pos_q <= rem_next;
    end else if (state_q == ST_WRAP) begin
      pos_q <= sum_wrap[POS_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      playing_q <= 1'b0;
    end else if (is_tick) begin
      playing_q <= in_gate && (len != '0);
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (is_tick) begin
          start_q      <= in_start;
          speed_q      <= in_speed;
          reset_trig_q <= in_reset;
          op_q         <= {pos_q, {(PROD_W-POS_W){1'b0}}};
          rem_q        <= '0;
          cnt_q        <= CNT_W'(POS_W);
        end
      end
      ST_MUL: begin
        op_q  <= prod;
        rem_q <= '0;
        cnt_q <= CNT_W'(PROD_W);
      end
      ST_MOD_RST, ST_MOD_POS, ST_MOD_SPD: begin
        op_q  <= {op_q[PROD_W-2:0], 1'b0};
        rem_q <= rem_next;
        cnt_q <= cnt_q - CNT_W'(1);
      end
      ST_READ1: s0_q <= rd_q;
      ST_IMUL: begin
        dprod_q <= diff * $signed({1'b0, pos_q[FRAC_W-1:0]});
        op_q    <= {speed_mag, {(PROD_W-SPEED_W){1'b0}}};
        rem_q   <= (SPAN_W'(speed_mag) < span) ? POS_W'(speed_mag) : '0;
        cnt_q   <= CNT_W'(SPEED_W);
      end
      ST_ADD: begin
        sum_q <= speed_q[SPEED_W-1] ? {2'b00, pos_q} - {2'b00, rem_q}
                                    : {2'b00, pos_q} + {2'b00, rem_q};
        res_q <= interp[SAMPLE_W-1:0];
      end
      default: begin
        cnt_q <= cnt_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
      m_data_q  <= '0;
      m_user_q  <= 1'b0;
    end else if (state_q == ST_DONE && out_free) begin
      m_valid_q <= 1'b1;
      m_data_q  <= playing_q ? res_q : '0;
      m_user_q  <= playing_q;
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  ap_rem_below_span: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_MOD_RST || state_q == ST_MOD_POS || state_q == ST_MOD_SPD)
    |-> (SPAN_W'(rem_q) < span && cnt_q != '0))
    else $error("remainder unit out of range");

  ap_pos_wrapped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_WRAP && !cfg_valid_i) |=> (SPAN_W'(pos_q) < span))
    else $error("play position not wrapped into the table span");

  ap_silent_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_valid_q && !m_user_q) |-> (m_data_q == '0))
    else $error("nonzero sample while not playing");

  ap_result_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_valid_q) |-> ($past(state_q) == ST_DONE))
    else $error("result issued outside the done step");

  ap_reload_path: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_MUL) |-> (reset_trig_q && len != '0))
    else $error("position reload without trigger");

endmodule

// ===== test/sample_player_linear_interp_top_test.sv =====
// ----------------------------------------------------------------------------
// sample_player_linear_interp_top_test
// Self-checking bench for the one-channel sample player.
//
// Write and tick items go in on s_axis. Every accepted tick is run through a
// bit-accurate player model kept in the bench, and the predicted sample and
// playing flag are queued. Each item on m_axis is checked against the oldest
// prediction. Directed ticks hit the interpolation extremes, the sample rate
// extremes, an empty table, a stale position and the full table depth. Random
// phases follow, each with its own table length and rate. The sender runs in
// bursts and the receiver stalls in modes of its own, with one long hold-off.
// Ticks that would read a sample never written are sent with the gate low.
// ----------------------------------------------------------------------------
module sample_player_linear_interp_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  import spli_pkg::*;

  typedef struct packed {
    bit        cmd;
    bit        reload;
    bit        gate;
    bit [31:0] start;
    bit [23:0] speed;
    bit [15:0] waddr;
    bit [15:0] wdata;
  } play_item_t;

  typedef struct packed {
    bit        playing;
    bit [15:0] sample;
  } sample_res_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata;
  logic                  s_axis_tuser;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  m_axis_tuser;
  logic                  cfg_valid_i;
  logic                  cfg_ready_o;
  logic                  cfg_addr_i;
  logic [CFG_W-1:0]      cfg_data_i;

  sample_player_linear_interp_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_data_i    (cfg_data_i)
  );

  // player model state
  bit signed [15:0]  smem [TABLE_DEPTH];
  bit                written [TABLE_DEPTH];
  longint unsigned   cur_pos;
  int unsigned       tbl_len;
  int unsigned       rate;

  sample_res_t       pending_samples [$];
  sample_res_t       want;

  int unsigned       mismatches;
  int unsigned       ticks_sent;
  int unsigned       writes_sent;
  int unsigned       gated_off;
  int unsigned       results_checked;
  int unsigned       playing_seen;
  int unsigned       reg_writes;

  // sender and receiver pacing
  bit                steady_send;
  int unsigned       burst_left;
  int unsigned       hold_request;
  int unsigned       hold_left;
  int unsigned       rx_mode;
  int unsigned       rx_left;

  always #5 clk_i = ~clk_i;

  initial begin
    #20_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  function automatic play_item_t tick_item(input bit reload, input bit gate,
                                           input bit [31:0] start,
                                           input bit [23:0] speed);
    play_item_t it;
    it = '0;
    it.cmd    = CMD_TICK;
    it.reload = reload;
    it.gate   = gate;
    it.start  = start;
    it.speed  = speed;
    return it;
  endfunction

  function automatic play_item_t write_item(input bit [15:0] addr, input bit [15:0] data);
    play_item_t it;
    it = '0;
    it.cmd   = CMD_WRITE;
    it.waddr = addr;
    it.wdata = data;
    it.start = $urandom;
    it.speed = 24'($urandom);
    return it;
  endfunction

  // Returns 0 when the tick would read a sample never written.
  function automatic bit step_player(input play_item_t it, input bit commit,
                                     output sample_res_t res);
    longint unsigned len, span, pos, prod, i0, i1;
    longint          s0, s1, frac, sum;
    bit              safe;
    safe = 1'b1;
    res  = '0;
    len  = (tbl_len < TABLE_DEPTH) ? tbl_len : TABLE_DEPTH;
    span = len << FRAC_W;
    pos  = cur_pos;
    if (it.cmd == CMD_WRITE) begin
      if (commit) begin
        smem[it.waddr]    = it.wdata;
        written[it.waddr] = 1'b1;
      end
      return 1'b1;
    end
    if (it.reload && len != 0) begin
      prod = it.start;
      prod = prod * rate;
      pos  = prod % span;
    end
    if (it.gate && len != 0) begin
      pos  = pos % span;
      i0   = pos >> FRAC_W;
      i1   = (i0 + 1) % len;
      safe = written[i0] && written[i1];
      s0   = smem[i0];
      s1   = smem[i1];
      frac = pos & 64'hFFFF;
      sum  = s0 + (((s1 - s0) * frac) >>> FRAC_W);
      res.sample  = sum[15:0];
      res.playing = 1'b1;
      sum = longint'(pos) + longint'($signed(it.speed));
      sum = sum % longint'(span);
      if (sum < 0) begin
        sum = sum + longint'(span);
      end
      pos = sum;
    end
    if (commit) begin
      cur_pos = pos;
    end
    return safe;
  endfunction

  function automatic int unsigned pick_gap();
    if (steady_send) begin
      return 0;
    end
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      return $urandom_range(1, 6);
    end
    burst_left--;
    return 0;
  endfunction

  function automatic play_item_t random_item(input int unsigned write_pct);
    play_item_t  it;
    int unsigned len, lim;
    len = (tbl_len < TABLE_DEPTH) ? tbl_len : TABLE_DEPTH;
    if ($urandom_range(0, 99) < write_pct) begin
      if (len != 0 && $urandom_range(0, 1) == 1) begin
        return write_item(16'($urandom_range(0, len - 1)), 16'($urandom));
      end
      return write_item(16'($urandom), 16'($urandom));
    end
    it = tick_item($urandom_range(0, 9) == 0, $urandom_range(0, 7) != 0, 32'd0, 24'd0);
    if ($urandom_range(0, 1) == 1) begin
      it.start = $urandom;
    end else begin
      it.start = $urandom_range(0, 32'h0040_0000);
    end
    lim = (len >= 127) ? 32'h7F_FFFF : (len << FRAC_W) + 1;
    case ($urandom_range(0, 3))
      0: it.speed = 24'($urandom);
      1: it.speed = 24'($urandom_range(0, 32'h3_FFFF) - 32'h1_FFFF);
      2: it.speed = 24'($urandom_range(0, 2 * lim) - lim);
      default: begin
        case ($urandom_range(0, 2))
          0: it.speed = 24'h7F_FFFF;
          1: it.speed = 24'h80_0000;
          default: it.speed = 24'h00_0000;
        endcase
      end
    endcase
    return it;
  endfunction

  task automatic send_item(input play_item_t it);
    int unsigned gap;
    sample_res_t res;
    gap = pick_gap();
    if (it.cmd == CMD_TICK && !step_player(it, 1'b0, res)) begin
      it.gate = 1'b0;
      gated_off++;
    end
    @(negedge clk_i);
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= it.cmd;
    s_axis_tdata  <= {6'd0, it.wdata, it.waddr, it.speed, it.start, it.gate, it.reload};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    void'(step_player(it, 1'b1, res));
    if (it.cmd == CMD_TICK) begin
      pending_samples.push_back(res);
      ticks_sent++;
    end else begin
      writes_sent++;
    end
  endtask

  task automatic quiet_input();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
  endtask

  task automatic settle();
    quiet_input();
    while (pending_samples.size() != 0) @(posedge clk_i);
    repeat (16) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic idx, input int unsigned val);
    settle();
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_addr_i  <= idx;
    cfg_data_i  <= CFG_W'(val);
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    if (idx == REG_TABLE_LENGTH) begin
      tbl_len = val & 32'h1_FFFF;
    end else begin
      rate = val & 32'h3_FFFF;
    end
    reg_writes++;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic test_empty_table();
    send_item(tick_item(1'b1, 1'b1, 32'h1234_5678, 24'h01_0000));
    send_item(tick_item(1'b0, 1'b0, 32'h0000_0000, 24'hFF_FFFF));
  endtask

  task automatic test_interp_extremes();
    send_item(write_item(16'd0, 16'h7FFF));
    send_item(write_item(16'd1, 16'h8000));
    send_item(write_item(16'd2, 16'hFFFF));
    send_item(write_item(16'd3, 16'h0000));
    write_reg(REG_TABLE_LENGTH, 4);
    write_reg(REG_SAMPLE_RATE, 1);
    send_item(tick_item(1'b1, 1'b1, 32'h0000_8000, 24'h01_8000));
    send_item(tick_item(1'b0, 1'b1, 32'h0000_0000, 24'h7F_FFFF));
    send_item(tick_item(1'b0, 1'b1, 32'h0000_0000, 24'h80_0000));
    send_item(tick_item(1'b0, 1'b0, 32'h0000_0000, 24'h12_3456));
    send_item(tick_item(1'b1, 1'b1, 32'hFFFF_FFFF, 24'hFF_FFFF));
  endtask

  task automatic test_rate_extremes();
    write_reg(REG_SAMPLE_RATE, 0);
    send_item(tick_item(1'b1, 1'b1, 32'hFFFF_FFFF, 24'h01_0000));
    write_reg(REG_SAMPLE_RATE, 192000);
    send_item(tick_item(1'b1, 1'b1, 32'hFFFF_FFFF, 24'h00_0000));
  endtask

  task automatic test_stale_position();
    write_reg(REG_SAMPLE_RATE, 1);
    send_item(tick_item(1'b1, 1'b0, 32'h0003_8000, 24'h00_0000));
    write_reg(REG_TABLE_LENGTH, 2);
    send_item(tick_item(1'b0, 1'b1, 32'h0000_0000, 24'h00_0000));
    write_reg(REG_TABLE_LENGTH, 1);
    send_item(tick_item(1'b0, 1'b1, 32'h0000_0000, 24'h01_0000));
  endtask

  task automatic test_full_depth();
    write_reg(REG_TABLE_LENGTH, LEN_MAX);
    send_item(tick_item(1'b1, 1'b1, 32'h0000_0000, 24'h00_4000));
    send_item(write_item(16'hFFFF, 16'h8001));
    send_item(tick_item(1'b1, 1'b1, 32'hFFFF_8000, 24'h01_0000));
    send_item(tick_item(1'b0, 1'b1, 32'h0000_0000, 24'h00_0000));
  endtask

  task automatic test_random_phases();
    int unsigned lens  [12] = '{1, 2, 3, 5, 16, 64, 37, 65536, 8, 0, 64, 12};
    int unsigned rates [12] = '{1, 192000, 48000, 0, 44100, 1, 96000, 1, 0, 22050,
                                192000, 0};
    int unsigned fill;
    for (int p = 0; p < 12; p++) begin
      write_reg(REG_TABLE_LENGTH, lens[p]);
      write_reg(REG_SAMPLE_RATE, (rates[p] == 0) ? $urandom_range(1, 192000) : rates[p]);
      steady_send = (p % 3 == 0);
      fill = (lens[p] > 64) ? 64 : lens[p];
      for (int a = 0; a < fill; a++) begin
        if (!written[a]) begin
          send_item(write_item(16'(a), 16'($urandom)));
        end
      end
      for (int n = 0; n < 125; n++) begin
        send_item(random_item(10));
      end
    end
    steady_send = 1'b0;
  endtask

  task automatic test_backpressure();
    write_reg(REG_TABLE_LENGTH, 16);
    hold_request = 400;
    steady_send  = 1'b1;
    for (int n = 0; n < 30; n++) begin
      send_item(random_item(0));
    end
    steady_send = 1'b0;
  endtask

  task automatic test_drain_pause();
    for (int n = 0; n < 20; n++) begin
      send_item(random_item(10));
    end
    settle();
    for (int n = 0; n < 20; n++) begin
      send_item(random_item(10));
    end
  endtask

  // receiver: modes of random length, plus a counted hold-off on request
  always @(negedge clk_i) begin
    if (hold_request != 0) begin
      hold_left    = hold_request;
      hold_request = 0;
    end
    if (hold_left != 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      if (rx_left == 0) begin
        rx_mode = $urandom_range(0, 2);
        rx_left = $urandom_range(10, 150);
      end
      rx_left--;
      case (rx_mode)
        0: m_axis_tready <= 1'b1;
        1: m_axis_tready <= ($urandom_range(0, 3) != 0);
        default: m_axis_tready <= ($urandom_range(0, 2) == 0);
      endcase
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_samples.size() == 0) begin
        $display("%0t ns: result with none expected, expected none, actual sample %h playing %b",
                 $time, m_axis_tdata, m_axis_tuser);
        mismatches++;
      end else begin
        want = pending_samples.pop_front();
        if (m_axis_tdata !== want.sample) begin
          $display("%0t ns: sample_out mismatch, expected %h, actual %h",
                   $time, want.sample, m_axis_tdata);
          mismatches++;
        end
        if (m_axis_tuser !== want.playing) begin
          $display("%0t ns: playing mismatch, expected %b, actual %b",
                   $time, want.playing, m_axis_tuser);
          mismatches++;
        end
        if (want.playing) begin
          playing_seen++;
        end
      end
      results_checked++;
    end
  end

  initial begin
    clk_i         = 1'b0;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = 1'b0;
    m_axis_tready = 1'b0;
    cfg_valid_i   = 1'b0;
    cfg_addr_i    = 1'b0;
    cfg_data_i    = '0;
    cur_pos       = 0;
    tbl_len       = 0;
    rate          = RATE_RESET;
    steady_send   = 1'b0;
    burst_left    = 0;
    hold_request  = 0;
    hold_left     = 0;
    rx_mode       = 0;
    rx_left       = 0;
    mismatches    = 0;
    ticks_sent    = 0;
    writes_sent   = 0;
    gated_off     = 0;
    results_checked = 0;
    playing_seen  = 0;
    reg_writes    = 0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_empty_table();
    test_interp_extremes();
    test_rate_extremes();
    test_stale_position();
    test_full_depth();
    test_random_phases();
    test_backpressure();
    test_drain_pause();

    quiet_input();
    while (pending_samples.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);

    $display("Covered %0d ticks (%0d playing, %0d held gate low) and %0d sample writes,",
             ticks_sent, playing_seen, gated_off, writes_sent);
    $display("%0d register writes, %0d results checked, %0d mismatches.",
             reg_writes, results_checked, mismatches);
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
